### src/cbc_pkg.sv
// Shared types and codes for the cartridge bank controller.
// No dependencies; used by the controller and its port checker.
package cbc_pkg;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MBC1 = 2'd1,
      KIND_MBC2 = 2'd2,
      KIND_MBC3 = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_ROM  = 2'd1,
      TGT_RAM  = 2'd2,
      TGT_RTC  = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ILLEGAL  = 2'd1,
      ST_RAM_OFF  = 2'd2,
      ST_UNMAPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_ROM = 2'd0,
      MODE_RAM = 2'd1,
      MODE_RTC = 2'd2
   } bank_mode_type;

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] LATCH_ARM      = 8'h00;
   localparam logic [7:0] LATCH_FIRE     = 8'h01;
   localparam logic [7:0] RTC_SEL_FIRST  = 8'h08;
   localparam logic [7:0] RTC_SEL_END    = 8'h0D;

   typedef struct packed {
      logic        mode;
      logic [15:0] bus_addr;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [20:0] mem_addr;
      logic        write_strobe;
      logic [7:0]  write_byte;
      logic [2:0]  rtc_index;
      logic        latch_pulse;
      status_type  status;
   } rsp_type;

endpackage

### src/cartridge_bank_controller.sv
// Cartridge bank controller: bus access decode, bank registers and address mapping.
// Depends on cbc_pkg for payload structs and code enums.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   req     | in        | req_valid / req_ready | cbc_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | cbc_pkg::rsp_type
//   csr     | in        | csr_write_en          | controller kind, 2 bits
//
// One request per cycle while results are taken; each passes an input register,
// then decode and bank mapping into the result register, where the bank
// registers also update. Both stages hold while the result is not taken; the
// input stage still takes a request whenever it moves on in the same cycle.
// Synchronous reset clears valids, the kind and most bank registers; it sets
// the ROM page to 1 and arms the latch.
module cartridge_bank_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbc_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_write_data
);
   import cbc_pkg::*;

   kind_type      kind_ff;
   logic          s1_valid_ff;
   req_type       s1_req_ff;
   logic          out_valid_ff;
   rsp_type       out_rsp_ff;

   logic [6:0]    rom_page_ff, rom_page_in;
   logic [2:0]    ram_page_ff, ram_page_in;
   logic          ram_en_ff, ram_en_in;
   bank_mode_type bank_mode_ff, bank_mode_in;
   logic [2:0]    rtc_sel_ff, rtc_sel_in;
   logic          latch_zero_ff, latch_zero_in;
   rsp_type       rsp_in;

   logic          s1_advance;
   logic          wr;
   logic [15:0]   addr;
   logic [7:0]    data;
   logic [2:0]    ram_page_use;
   logic [6:0]    rom_page_use;
   logic [4:0]    b5;
   logic [3:0]    b4;
   logic [6:0]    b7;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_rsp_ff;

   assign wr   = (s1_req_ff.mode == ACC_WRITE);
   assign addr = s1_req_ff.bus_addr;
   assign data = s1_req_ff.bus_data;

   assign b5 = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
   assign b4 = (data[3:0] == 4'd0) ? 4'd1 : data[3:0];
   assign b7 = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];

   assign rom_page_use = (kind_ff == KIND_NONE) ? 7'd1 : rom_page_ff;
   assign ram_page_use = ((kind_ff == KIND_MBC3) ||
                          (kind_ff == KIND_MBC1 && bank_mode_ff == MODE_RAM))
                         ? ram_page_ff : 3'd0;

   always_comb begin
      rsp_in        = '0;
      rsp_in.target = TGT_NONE;
      rsp_in.status = ST_OK;
      rom_page_in   = rom_page_ff;
      ram_page_in   = ram_page_ff;
      ram_en_in     = ram_en_ff;
      bank_mode_in  = bank_mode_ff;
      rtc_sel_in    = rtc_sel_ff;
      latch_zero_in = latch_zero_ff;

      if (addr[15:13] == 3'b101) begin
         // external RAM window
         if (!ram_en_ff) begin
            rsp_in.status = ST_RAM_OFF;
         end else if (kind_ff == KIND_MBC2) begin
            if (addr[12:9] != 4'd0) begin
               rsp_in.status = wr ? ST_ILLEGAL : ST_UNMAPPED;
            end else begin
               rsp_in.target   = TGT_RAM;
               rsp_in.mem_addr = {12'd0, addr[8:0]};
               if (wr) begin
                  rsp_in.write_strobe = 1'b1;
                  rsp_in.write_byte   = {4'd0, data[3:0]};
               end
            end
         end else if (kind_ff == KIND_MBC3 && bank_mode_ff == MODE_RTC) begin
            rsp_in.target    = TGT_RTC;
            rsp_in.rtc_index = rtc_sel_ff;
            if (wr) begin
               rsp_in.write_strobe = 1'b1;
               rsp_in.write_byte   = data;
            end
         end else begin
            rsp_in.target   = TGT_RAM;
            rsp_in.mem_addr = {5'd0, ram_page_use, addr[12:0]};
            if (wr) begin
               rsp_in.write_strobe = 1'b1;
               rsp_in.write_byte   = data;
            end
         end
      end else if (addr[15]) begin
         rsp_in.status = ST_UNMAPPED;
      end else if (!wr) begin
         rsp_in.target = TGT_ROM;
         if (!addr[14]) begin
            rsp_in.mem_addr = {5'd0, addr};
         end else begin
            rsp_in.mem_addr = {rom_page_use, addr[13:0]};
         end
      end else if (addr[14:13] == 2'b00) begin
         // RAM enable; MBC2 ignores it when bit 4 is set
         if (!(kind_ff == KIND_MBC2 && data[4])) begin
            ram_en_in = (data[3:0] == RAM_ENABLE_KEY);
         end
      end else if (kind_ff == KIND_NONE || (kind_ff == KIND_MBC2 && addr[14])) begin
         rsp_in.status = ST_ILLEGAL;
      end else if (!addr[14]) begin
         case (kind_ff)
            KIND_MBC1: rom_page_in = {rom_page_ff[6:5], b5};
            KIND_MBC2: begin
               if (data[4]) begin
                  rom_page_in = {3'd0, b4};
               end
            end
            default:   rom_page_in = b7;
         endcase
      end else if (!addr[13]) begin
         if (kind_ff == KIND_MBC1) begin
            if (bank_mode_ff == MODE_RAM) begin
               ram_page_in = {1'b0, data[1:0]};
            end else begin
               rom_page_in = {data[1:0], rom_page_ff[4:0]};
            end
         end else if (data < RTC_SEL_FIRST) begin
            ram_page_in  = data[2:0];
            bank_mode_in = MODE_RAM;
         end else if (data < RTC_SEL_END) begin
            // 0x08..0x0C: low three bits already equal value minus 8
            rtc_sel_in   = data[2:0];
            bank_mode_in = MODE_RTC;
         end
      end else begin
         if (kind_ff == KIND_MBC1) begin
            if (data == 8'd0) begin
               bank_mode_in = MODE_ROM;
            end else if (data == 8'd1) begin
               bank_mode_in = MODE_RAM;
            end
         end else begin
            rsp_in.latch_pulse = latch_zero_ff && (data == LATCH_FIRE);
            latch_zero_in      = (data == LATCH_ARM);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_NONE;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         rom_page_ff   <= 7'd1;
         ram_page_ff   <= 3'd0;
         ram_en_ff     <= 1'b0;
         bank_mode_ff  <= MODE_ROM;
         rtc_sel_ff    <= 3'd0;
         latch_zero_ff <= 1'b1;
      end else begin
         if (csr_write_en) begin
            kind_ff <= kind_type'(csr_write_data);
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            out_valid_ff  <= 1'b1;
            rom_page_ff   <= rom_page_in;
            ram_page_ff   <= ram_page_in;
            ram_en_ff     <= ram_en_in;
            bank_mode_ff  <= bank_mode_in;
            rtc_sel_ff    <= rtc_sel_in;
            latch_zero_ff <= latch_zero_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_req_ff <= req_data;
      end
      if (s1_advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

endmodule

### src/cbc_checker.sv
// Port-level checks for the cartridge bank controller, bound to that module.
// Depends on cbc_pkg and on cartridge_bank_controller port names.
module cbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cbc_pkg::rsp_type rsp_data
);
   import cbc_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the result was taken");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target != TGT_ROM && rsp_data.target != TGT_RAM
      |-> rsp_data.mem_addr == 21'd0)
      else $error("mem_addr set for a target without memory");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_strobe |-> rsp_data.write_byte == 8'd0)
      else $error("write_byte set without write_strobe");

   a_fail_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK
      |-> rsp_data.target == TGT_NONE && !rsp_data.write_strobe && !rsp_data.latch_pulse)
      else $error("failed request still selected a target");

   a_latch_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.latch_pulse
      |-> rsp_data.target == TGT_NONE && !rsp_data.write_strobe)
      else $error("latch pulse combined with a data access");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);
